>>> rtl/chg_pkg.sv
// Shared types for the gift-wrap convex hull block.
// Used by chg_turn and convex_hull_gift_wrap; depends on nothing.
`timescale 1ns / 1ps

package chg_pkg;

    // hull_size field width on the result channel
    localparam int unsigned SIZE_BITS = 7;

    // product schedule of the turn unit
    typedef enum logic [3:0] {
        OP_UX_WY = 4'd0,
        OP_UY_WX = 4'd1,
        OP_UX_WX = 4'd2,
        OP_UY_WY = 4'd3,
        OP_EX_UX = 4'd4,
        OP_EY_UY = 4'd5,
        OP_EX_WX = 4'd6,
        OP_EY_WY = 4'd7,
        OP_UX_UX = 4'd8,
        OP_UY_UY = 4'd9,
        OP_WX_WX = 4'd10,
        OP_WY_WY = 4'd11
    } op_t;

    // request to and response from the turn unit
    typedef struct packed {
        logic start;
    } turn_req_t;

    typedef struct packed {
        logic done;
        logic less;
    } turn_rsp_t;

endpackage

>>> rtl/chg_store.sv
// Point store: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module chg_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/chg_turn.sv
// Turn comparison unit: one shared multiplier run over twelve products,
// then a registered decision. Depends on chg_pkg.
`timescale 1ns / 1ps

module chg_turn #(
    parameter int unsigned CB = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  chg_pkg::turn_req_t    req,
    input  logic signed [CB-1:0]  cur_x,
    input  logic signed [CB-1:0]  cur_y,
    input  logic signed [CB-1:0]  cand_x,
    input  logic signed [CB-1:0]  cand_y,
    input  logic signed [CB-1:0]  best_x,
    input  logic signed [CB-1:0]  best_y,
    input  logic signed [CB:0]    edge_x,
    input  logic signed [CB:0]    edge_y,
    output chg_pkg::turn_rsp_t    rsp
);

    localparam int unsigned PW    = 2 * CB + 2;
    localparam int unsigned ACC_W = 2 * CB + 3;

    logic signed [CB:0] ux, uy, wx, wy;
    logic signed [CB:0] opa, opb;

    logic               busy_reg, busy_next;
    chg_pkg::op_t       op_reg, op_next;
    logic               pv_reg;
    chg_pkg::op_t       pop_reg;
    logic signed [PW-1:0] prod_reg;
    logic               fin_reg, done_reg, less_reg;
    logic signed [ACC_W-1:0] acc_reg [6];
    logic signed [ACC_W-1:0] pext;
    logic [2:0]         acc_idx;
    logic               decide;

    // offsets from the current vertex: u for the candidate, w for the best
    assign ux = {cand_x[CB-1], cand_x} - {cur_x[CB-1], cur_x};
    assign uy = {cand_y[CB-1], cand_y} - {cur_y[CB-1], cur_y};
    assign wx = {best_x[CB-1], best_x} - {cur_x[CB-1], cur_x};
    assign wy = {best_y[CB-1], best_y} - {cur_y[CB-1], cur_y};

    // operand selection for the shared multiplier
    always_comb begin
        case (op_reg)
            chg_pkg::OP_UX_WY: begin opa = ux;     opb = wy; end
            chg_pkg::OP_UY_WX: begin opa = uy;     opb = wx; end
            chg_pkg::OP_UX_WX: begin opa = ux;     opb = wx; end
            chg_pkg::OP_UY_WY: begin opa = uy;     opb = wy; end
            chg_pkg::OP_EX_UX: begin opa = edge_x; opb = ux; end
            chg_pkg::OP_EY_UY: begin opa = edge_y; opb = uy; end
            chg_pkg::OP_EX_WX: begin opa = edge_x; opb = wx; end
            chg_pkg::OP_EY_WY: begin opa = edge_y; opb = wy; end
            chg_pkg::OP_UX_UX: begin opa = ux;     opb = ux; end
            chg_pkg::OP_UY_UY: begin opa = uy;     opb = uy; end
            chg_pkg::OP_WX_WX: begin opa = wx;     opb = wx; end
            chg_pkg::OP_WY_WY: begin opa = wy;     opb = wy; end
            default:           begin opa = '0;     opb = '0; end
        endcase
    end

    // sequencer
    always_comb begin
        busy_next = busy_reg;
        op_next   = op_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = chg_pkg::OP_UX_WY;
        end else if (busy_reg) begin
            if (op_reg == chg_pkg::OP_WY_WY) begin
                busy_next = 1'b0;
            end else begin
                op_next = chg_pkg::op_t'(op_reg + 4'd1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            op_reg   <= chg_pkg::OP_UX_WY;
            pv_reg   <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
            pv_reg   <= busy_reg;
            fin_reg  <= pv_reg && (pop_reg == chg_pkg::OP_WY_WY);
            done_reg <= fin_reg;
        end
    end

    // product register
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(opa * opb);
        pop_reg  <= op_reg;
    end

    // pairwise sums: cross, dot, edge.u, edge.w, |u|^2, |w|^2
    assign pext    = {prod_reg[PW-1], prod_reg};
    assign acc_idx = pop_reg[3:1];

    always_ff @(posedge aclk) begin
        if (pv_reg) begin
            if (!pop_reg[0]) begin
                acc_reg[acc_idx] <= pext;
            end else if (pop_reg == chg_pkg::OP_UY_WX) begin
                acc_reg[acc_idx] <= acc_reg[acc_idx] - pext;
            end else begin
                acc_reg[acc_idx] <= acc_reg[acc_idx] + pext;
            end
        end
    end

    // candidate turns less than the best so far
    always_comb begin
        if (acc_reg[0] != '0) begin
            decide = acc_reg[0] > 0;
        end else if (acc_reg[1] < 0 && acc_reg[2] != acc_reg[3]) begin
            decide = acc_reg[2] > acc_reg[3];
        end else begin
            decide = acc_reg[4] > acc_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_reg) begin
            less_reg <= decide;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.less = less_reg;

endmodule

>>> rtl/convex_hull_gift_wrap.sv
// Gift-wrap convex hull. Points load at one beat per cycle; a last point
// starts the search: each point is read and compared for the lowest-point scan,
// then each hull step reads entry k and every later candidate, with a turn test for
// each one that differs from the current vertex (chg_turn runs twelve products).
// Vertices then leave one at a time. One point set at a time.
// aresetn (synchronous) empties the store; stored data is not cleared.
`timescale 1ns / 1ps

module convex_hull_gift_wrap #(
    parameter int unsigned POINTS     = 64,
    parameter int unsigned COORD_BITS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    // point_x, point_y (low bits up), zero padded
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hull_x, hull_y, hull_size (low bits up), zero padded
    output logic [((2*COORD_BITS+chg_pkg::SIZE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    localparam int unsigned CB    = COORD_BITS;
    localparam int unsigned IDX   = $clog2(POINTS);
    localparam int unsigned CNT   = $clog2(POINTS + 1);
    localparam int unsigned OUT_W = ((2*CB+chg_pkg::SIZE_BITS+7)/8)*8;

    typedef enum logic [12:0] {
        S_LOAD    = 13'b0000000000001,
        S_LOW_RD  = 13'b0000000000010,
        S_LOW_CMP = 13'b0000000000100,
        S_K_RD    = 13'b0000000001000,
        S_K_GET   = 13'b0000000010000,
        S_C_RD    = 13'b0000000100000,
        S_C_GET   = 13'b0000001000000,
        S_C_WAIT  = 13'b0000010000000,
        S_SWAP1   = 13'b0000100000000,
        S_SWAP2   = 13'b0001000000000,
        S_E_RD    = 13'b0010000000000,
        S_E_GET   = 13'b0100000000000,
        S_E_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT-1:0] cnt_reg, cnt_next;
    logic [CNT-1:0] n_reg, n_next;
    logic [CNT-1:0] i_reg, i_next;
    logic [CNT-1:0] k_reg, k_next;
    logic [IDX-1:0] bidx_reg, bidx_next;

    logic signed [CB-1:0] lo_x_reg, lo_x_next, lo_y_reg, lo_y_next;
    logic signed [CB-1:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [CB-1:0] best_x_reg, best_x_next, best_y_reg, best_y_next;
    logic signed [CB-1:0] cand_x_reg, cand_x_next, cand_y_reg, cand_y_next;
    logic [2*CB-1:0]      kval_reg, kval_next;
    logic signed [CB:0]   ex_reg, ex_next, ey_reg, ey_next;

    logic signed [CB-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                 out_last_reg, out_last_next;

    logic            we;
    logic [IDX-1:0]  waddr, raddr;
    logic [2*CB-1:0] wdata, rdata;
    logic signed [CB-1:0] rd_x, rd_y;

    chg_pkg::turn_req_t treq;
    chg_pkg::turn_rsp_t trsp;

    assign rd_x = rdata[CB-1:0];
    assign rd_y = rdata[2*CB-1:CB];

    chg_store #(
        .DEPTH (POINTS),
        .WIDTH (2 * CB)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    chg_turn #(
        .CB (CB)
    ) u_turn (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (treq),
        .cur_x   (cur_x_reg),
        .cur_y   (cur_y_reg),
        .cand_x  (cand_x_reg),
        .cand_y  (cand_y_reg),
        .best_x  (best_x_reg),
        .best_y  (best_y_reg),
        .edge_x  (ex_reg),
        .edge_y  (ey_reg),
        .rsp     (trsp)
    );

    assign s_tready = (state_reg == S_LOAD);
    assign m_tvalid = (state_reg == S_E_OUT);
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({k_reg, out_y_reg, out_x_reg});

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        bidx_next     = bidx_reg;
        lo_x_next     = lo_x_reg;
        lo_y_next     = lo_y_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        best_x_next   = best_x_reg;
        best_y_next   = best_y_reg;
        cand_x_next   = cand_x_reg;
        cand_y_next   = cand_y_reg;
        kval_next     = kval_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        out_x_next    = out_x_reg;
        out_y_next    = out_y_reg;
        out_last_next = out_last_reg;
        we            = 1'b0;
        waddr         = cnt_reg[IDX-1:0];
        wdata         = s_tdata[2*CB-1:0];
        raddr         = i_reg[IDX-1:0];
        treq.start    = 1'b0;

        case (state_reg)
            // take points until the last beat
            S_LOAD: begin
                if (s_tvalid) begin
                    if (cnt_reg < CNT'(POINTS)) begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + CNT'(1);
                    end
                    if (s_tlast) begin
                        n_next     = cnt_next;
                        i_next     = '0;
                        state_next = S_LOW_RD;
                    end
                end
            end
            // lowest point, rightmost on a tie
            S_LOW_RD: begin
                state_next = S_LOW_CMP;
            end
            S_LOW_CMP: begin
                if (i_reg == '0 || rd_y < lo_y_reg ||
                    (rd_y == lo_y_reg && rd_x > lo_x_reg)) begin
                    lo_x_next = rd_x;
                    lo_y_next = rd_y;
                end
                i_next = i_reg + CNT'(1);
                if (i_next == n_reg) begin
                    cur_x_next = (i_reg == '0) ? rd_x : lo_x_next;
                    cur_y_next = lo_y_next;
                    ex_next    = (CB+1)'(1);
                    ey_next    = '0;
                    k_next     = '0;
                    state_next = S_K_RD;
                end else begin
                    state_next = S_LOW_RD;
                end
            end
            // first candidate of a step is entry k
            S_K_RD: begin
                raddr      = k_reg[IDX-1:0];
                state_next = S_K_GET;
            end
            S_K_GET: begin
                best_x_next = rd_x;
                best_y_next = rd_y;
                kval_next   = rdata;
                bidx_next   = k_reg[IDX-1:0];
                i_next      = k_reg + CNT'(1);
                state_next  = (i_next == n_reg) ? S_SWAP1 : S_C_RD;
            end
            S_C_RD: begin
                state_next = S_C_GET;
            end
            S_C_GET: begin
                cand_x_next = rd_x;
                cand_y_next = rd_y;
                if (rd_x == cur_x_reg && rd_y == cur_y_reg) begin
                    i_next     = i_reg + CNT'(1);
                    state_next = (i_next == n_reg) ? S_SWAP1 : S_C_RD;
                end else begin
                    treq.start = 1'b1;
                    state_next = S_C_WAIT;
                end
            end
            S_C_WAIT: begin
                if (trsp.done) begin
                    if ((best_x_reg == cur_x_reg && best_y_reg == cur_y_reg) ||
                        trsp.less) begin
                        best_x_next = cand_x_reg;
                        best_y_next = cand_y_reg;
                        bidx_next   = i_reg[IDX-1:0];
                    end
                    i_next     = i_reg + CNT'(1);
                    state_next = (i_next == n_reg) ? S_SWAP1 : S_C_RD;
                end
            end
            // swap chosen entry into place k
            S_SWAP1: begin
                we         = 1'b1;
                waddr      = bidx_reg;
                wdata      = kval_reg;
                state_next = S_SWAP2;
            end
            S_SWAP2: begin
                we         = 1'b1;
                waddr      = k_reg[IDX-1:0];
                wdata      = {best_y_reg, best_x_reg};
                ex_next    = {best_x_reg[CB-1], best_x_reg} - {cur_x_reg[CB-1], cur_x_reg};
                ey_next    = {best_y_reg[CB-1], best_y_reg} - {cur_y_reg[CB-1], cur_y_reg};
                cur_x_next = best_x_reg;
                cur_y_next = best_y_reg;
                k_next     = k_reg + CNT'(1);
                if (k_next == n_reg ||
                    (best_x_reg == lo_x_reg && best_y_reg == lo_y_reg)) begin
                    i_next     = '0;
                    state_next = S_E_RD;
                end else begin
                    state_next = S_K_RD;
                end
            end
            // emit entries 0 .. k-1
            S_E_RD: begin
                state_next = S_E_GET;
            end
            S_E_GET: begin
                out_x_next    = rd_x;
                out_y_next    = rd_y;
                out_last_next = (i_reg + CNT'(1) == k_reg);
                state_next    = S_E_OUT;
            end
            S_E_OUT: begin
                if (m_tready) begin
                    i_next = i_reg + CNT'(1);
                    if (out_last_reg) begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_E_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            cnt_reg      <= '0;
            k_reg        <= '0;
            out_last_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            k_reg        <= k_next;
            out_last_reg <= out_last_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        bidx_reg   <= bidx_next;
        lo_x_reg   <= lo_x_next;
        lo_y_reg   <= lo_y_next;
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        best_x_reg <= best_x_next;
        best_y_reg <= best_y_next;
        cand_x_reg <= cand_x_next;
        cand_y_reg <= cand_y_next;
        kval_reg   <= kval_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT'(POINTS))
        else $error("point count past store depth");

    a_turn_done: assert property (@(posedge aclk) disable iff (!aresetn)
        trsp.done |-> state_reg == S_C_WAIT)
        else $error("turn result outside wait");

    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (k_reg != '0 && k_reg <= n_reg))
        else $error("hull size out of range");

endmodule

>>> test/tb_convex_hull_gift_wrap.sv
// Self-checking testbench for convex_hull_gift_wrap: point sets in, hull vertices out.
// Depends on chg_pkg and the block RTL; holds its own hull predictor.
`timescale 1ns / 1ps

module tb_convex_hull_gift_wrap;

    localparam int NPTS   = 64;
    localparam int CB     = 16;
    localparam int S_W    = ((2*CB+7)/8)*8;
    localparam int M_W    = ((2*CB+chg_pkg::SIZE_BITS+7)/8)*8;
    localparam int LIMIT  = 3000000;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 last;
        logic                 drain; // hold until all vertices are back
    } point_beat_t;

    typedef struct {
        logic signed [CB-1:0]          x;
        logic signed [CB-1:0]          y;
        logic [chg_pkg::SIZE_BITS-1:0] size;
        logic                          last;
    } vertex_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic [S_W-1:0]   s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [M_W-1:0]   m_tdata;
    logic             m_tlast;
    logic             m_tvalid;
    logic             m_tready = 1'b0;

    point_beat_t pending_points[$];
    vertex_t     hull_expected[$];

    // predictor state
    int pts_x[NPTS];
    int pts_y[NPTS];
    int pts_n = 0;

    int  cyc = 0;
    int  errors = 0;
    int  vertices_seen = 0;
    int  sets_sent = 0;

    convex_hull_gift_wrap #(.POINTS(NPTS), .COORD_BITS(CB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // true when point a turns less than point b from vertex (cx, cy)
    function automatic bit turns_less(int a, int b, longint cx, longint cy,
                                      longint ex, longint ey);
        longint ux, uy, wx, wy, cr, du, dw;
        ux = pts_x[a] - cx; uy = pts_y[a] - cy;
        wx = pts_x[b] - cx; wy = pts_y[b] - cy;
        cr = ux * wy - uy * wx;
        if (cr > 0) return 1'b1;
        if (cr < 0) return 1'b0;
        if (ux * wx + uy * wy < 0) begin
            du = ex * ux + ey * uy;
            dw = ex * wx + ey * wy;
            if (du != dw) return du > dw;
        end
        return ux * ux + uy * uy > wx * wx + wy * wy;
    endfunction

    // store a point; on the last one wrap the hull and queue its vertices
    task automatic wrap_hull(point_beat_t p);
        int lo, k, best, t;
        longint sx, sy, cx, cy, ex, ey;
        vertex_t v;
        if (pts_n < NPTS) begin
            pts_x[pts_n] = p.x;
            pts_y[pts_n] = p.y;
            pts_n++;
        end
        if (!p.last) return;
        lo = 0;
        for (int i = 1; i < pts_n; i++)
            if (pts_y[i] < pts_y[lo] || (pts_y[i] == pts_y[lo] && pts_x[i] > pts_x[lo]))
                lo = i;
        sx = pts_x[lo]; sy = pts_y[lo];
        cx = sx; cy = sy; ex = 1; ey = 0;
        k = 0;
        do begin
            best = k;
            for (int i = k + 1; i < pts_n; i++) begin
                if (pts_x[i] == cx && pts_y[i] == cy) continue;
                if ((pts_x[best] == cx && pts_y[best] == cy) ||
                    turns_less(i, best, cx, cy, ex, ey))
                    best = i;
            end
            t = pts_x[best]; pts_x[best] = pts_x[k]; pts_x[k] = t;
            t = pts_y[best]; pts_y[best] = pts_y[k]; pts_y[k] = t;
            ex = pts_x[k] - cx; ey = pts_y[k] - cy;
            cx = pts_x[k]; cy = pts_y[k];
            k++;
        end while (k < pts_n && !(cx == sx && cy == sy));
        for (int i = 0; i < k; i++) begin
            v.x = CB'(pts_x[i]);
            v.y = CB'(pts_y[i]);
            v.size = chg_pkg::SIZE_BITS'(k);
            v.last = (i + 1 == k);
            hull_expected.push_back(v);
        end
        pts_n = 0;
    endtask

    function automatic bit quiet_window();
        return (cyc % 3000) < 700;
    endfunction

    // driver: one point beat per handshake
    always @(posedge aclk) begin
        point_beat_t nxt;
        bit hold;
        cyc <= cyc + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                wrap_hull(pending_points.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                hold = pending_points.size() == 0 ||
                       (pending_points[0].drain && hull_expected.size() != 0) ||
                       (!quiet_window() && $urandom_range(99) < 22);
                if (hold) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = pending_points[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.y, nxt.x};
                    s_tlast  <= nxt.last;
                end
            end
            m_tready <= quiet_window() || $urandom_range(99) >= 22;
        end
    end

    // monitor: check each vertex beat against the oldest prediction
    always @(posedge aclk) begin
        vertex_t e;
        if (aresetn && m_tvalid && m_tready) begin
            vertices_seen++;
            if (hull_expected.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected vertex x=%0d y=%0d", $signed(m_tdata[CB-1:0]),
                             $signed(m_tdata[2*CB-1:CB]));
            end else begin
                e = hull_expected.pop_front();
                if (m_tdata[CB-1:0] !== e.x || m_tdata[2*CB-1:CB] !== e.y ||
                    m_tdata[2*CB+chg_pkg::SIZE_BITS-1:2*CB] !== e.size ||
                    m_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"vertex mismatch: exp x=%0d y=%0d n=%0d l=%0b ",
                                  "got x=%0d y=%0d n=%0d l=%0b"},
                                 e.x, e.y, e.size, e.last,
                                 $signed(m_tdata[CB-1:0]), $signed(m_tdata[2*CB-1:CB]),
                                 m_tdata[2*CB+chg_pkg::SIZE_BITS-1:2*CB], m_tlast);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cyc > LIMIT) begin
            $display("timeout with %0d vertices outstanding", hull_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic add_point(int x, int y, bit last, bit drain = 1'b0);
        point_beat_t p;
        p.x = CB'(x); p.y = CB'(y); p.last = last; p.drain = drain;
        pending_points.push_back(p);
        if (last) sets_sent++;
    endtask

    // stimulus
    initial begin
        int n, span;
        bit wide;
        // single extreme point
        add_point(-32768, -32768, 1'b1);
        // all points equal
        add_point(32767, 32767, 1'b0);
        add_point(32767, 32767, 1'b0);
        add_point(32767, 32767, 1'b1);
        // full-range square with an inner point
        add_point(-32768, -32768, 1'b0);
        add_point(32767, -32768, 1'b0);
        add_point(32767, 32767, 1'b0);
        add_point(-32768, 32767, 1'b0);
        add_point(0, 0, 1'b1);
        // collinear set
        add_point(0, 0, 1'b0);
        add_point(5, 0, 1'b0);
        add_point(10, 0, 1'b0);
        add_point(-3, 0, 1'b1);
        // repeated vertices
        add_point(1, 1, 1'b0, 1'b1);
        add_point(1, 1, 1'b0);
        add_point(4, 1, 1'b0);
        add_point(1, 4, 1'b0);
        add_point(4, 1, 1'b1);
        // overfull store: the last two points are dropped
        for (int i = 0; i < NPTS + 2; i++)
            add_point($urandom_range(20) - 10, $urandom_range(20) - 10, i == NPTS + 1);

        // random sets, mostly small coordinates so ties and duplicates occur
        for (int items = 0; items < 16; items += n) begin
            n = $urandom_range(12, 1);
            wide = $urandom_range(2) == 0;
            span = $urandom_range(8, 1);
            for (int i = 0; i < n; i++) begin
                if (wide)
                    add_point($signed(16'($urandom)), $signed(16'($urandom)), i == n - 1,
                              i == 0 && $urandom_range(5) == 0);
                else
                    add_point($urandom_range(2*span) - span, $urandom_range(2*span) - span,
                              i == n - 1);
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_points.size() == 0);
        wait (hull_expected.size() == 0);
        repeat (300) @(posedge aclk);
        $display("%0d point sets hulled, %0d vertices checked", sets_sent, vertices_seen);
        $display("covered single, equal, collinear, repeated, overfull and random sets");
        if (errors == 0 && hull_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> convex_hull_gift_wrap.f
rtl/chg_pkg.sv
rtl/chg_store.sv
rtl/chg_turn.sv
rtl/convex_hull_gift_wrap.sv
test/tb_convex_hull_gift_wrap.sv
